@@ rtl/core/nac_pkg.sv @@
package nac_pkg;

    localparam int ENTRIES_DEF = 8;
    localparam int IP_W        = 64;
    localparam int MAC_W       = 48;
    localparam int STAMP_W     = 32;
    localparam int SLOT_W      = 3;
    localparam int S_DATA_W    = 208;
    localparam int M_DATA_W    = 56;

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_SAVE   = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // request held steady while the token walks the chain
    typedef struct packed
    {
        op_t                op;
        logic [IP_W-1:0]    ip_high;
        logic [IP_W-1:0]    ip_low;
        logic [MAC_W-1:0]   mac;
        logic [STAMP_W-1:0] now;
    } query_t;

    // token handed from cell to cell
    typedef struct packed
    {
        logic               active;
        logic [STAMP_W-1:0] old_stamp;
    } carry_t;

    typedef struct packed
    {
        logic             found;
        logic             hit;
        logic [MAC_W-1:0] mac;
    } result_t;

endpackage

@@ rtl/core/neighbor_address_cache_top.sv @@
// The token walks the chain of entry cells one cell per cycle; a hit, or an empty slot
// on a save, stops it at that entry, and a full scan (miss or oldest-entry replace) runs it
// off the end. One request at a time: a new request is taken only after the result is accepted.
// Reset: rst_n asynchronous, active low; clears every entry stamp, so the cache starts empty.
module neighbor_address_cache_top
    import nac_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // ip_high[63:0], ip_low[127:64], mac_address[175:128], now[207:176]
    input  logic [S_DATA_W-1:0] s_tdata,
    // operation
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // mac_out[47:0], slot[50:48], zero[55:51]
    output logic [M_DATA_W-1:0] m_tdata,
    // hit
    output logic                m_tuser
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    state_t            state_reg;
    state_t            state_next;
    query_t            q_reg;
    query_t            q_next;
    logic              start_reg;
    logic              start_next;
    logic              hit_reg;
    logic              hit_next;
    logic [MAC_W-1:0]  mac_reg;
    logic [MAC_W-1:0]  mac_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    carry_t            carry [0:ENTRIES];
    logic [IW-1:0]     oidx  [0:ENTRIES];
    result_t           res   [0:ENTRIES-1];

    logic              evict_en;
    logic              any_found;
    logic              found_hit;
    logic [MAC_W-1:0]  found_mac;
    logic [IW-1:0]     found_idx;

    assign carry[0].active    = start_reg;
    assign carry[0].old_stamp = '0;
    assign oidx[0]            = '0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            nac_cell #(
                .IW  (IW),
                .IDX (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .q         (q_reg),
                .carry_in  (carry[g]),
                .oidx_in   (oidx[g]),
                .evict_en  (evict_en),
                .evict_idx (oidx[ENTRIES]),
                .carry_out (carry[g+1]),
                .oidx_out  (oidx[g+1]),
                .res       (res[g])
            );
        end
    endgenerate

    // only the cell holding the token can report, so a plain OR merges them
    always_comb
    begin
        any_found = 1'b0;
        found_hit = 1'b0;
        found_mac = '0;
        found_idx = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            any_found = any_found | res[k].found;
            found_hit = found_hit | res[k].hit;
            found_mac = found_mac | res[k].mac;
            found_idx = found_idx | (res[k].found ? IW'(k) : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        hit_reg  <= hit_next;
        mac_reg  <= mac_next;
        slot_reg <= slot_next;
    end

    always_comb
    begin
        state_next = state_reg;
        q_next     = q_reg;
        start_next = 1'b0;
        hit_next   = hit_reg;
        mac_next   = mac_reg;
        slot_next  = slot_reg;
        evict_en   = 1'b0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    q_next.op      = op_t'(s_tuser);
                    q_next.ip_high = s_tdata[63:0];
                    q_next.ip_low  = s_tdata[127:64];
                    q_next.mac     = s_tdata[175:128];
                    q_next.now     = s_tdata[207:176];
                    start_next     = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (any_found)
                begin
                    hit_next   = found_hit;
                    mac_next   = found_mac;
                    slot_next  = SLOT_W'({{SLOT_W{1'b0}}, found_idx});
                    state_next = ST_DONE;
                end
                else if (carry[ENTRIES].active)
                begin
                    // token fell off the end: miss, or replace the oldest entry
                    evict_en   = (q_reg.op == OP_SAVE);
                    hit_next   = 1'b0;
                    mac_next   = '0;
                    slot_next  = (q_reg.op == OP_SAVE)
                                 ? SLOT_W'({{SLOT_W{1'b0}}, oidx[ENTRIES]}) : '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tdata = {(M_DATA_W - MAC_W - SLOT_W)'(0), slot_reg, mac_reg};
    assign m_tuser = hit_reg;

endmodule

@@ rtl/core/nac_cell.sv @@
module nac_cell
    import nac_pkg::*;
#(
    parameter int IW  = 3,
    parameter int IDX = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  query_t        q,
    input  carry_t        carry_in,
    input  logic [IW-1:0] oidx_in,
    input  logic          evict_en,
    input  logic [IW-1:0] evict_idx,
    output carry_t        carry_out,
    output logic [IW-1:0] oidx_out,
    output result_t       res
);

    logic [IP_W-1:0]    addr_hi_reg;
    logic [IP_W-1:0]    addr_lo_reg;
    logic [MAC_W-1:0]   link_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic [STAMP_W-1:0] stamp_next;
    carry_t             carry_reg;
    carry_t             carry_next;
    logic [IW-1:0]      oidx_reg;
    logic [IW-1:0]      oidx_next;

    logic used;
    logic match;
    logic stop;
    logic take_old;
    logic wr_all;
    logic wr_link;

    always_comb
    begin
        used     = (stamp_reg != '0);
        match    = used && (addr_hi_reg == q.ip_high) && (addr_lo_reg == q.ip_low);
        stop     = carry_in.active && (match || ((q.op == OP_SAVE) && !used));
        take_old = (IDX == 0) || (stamp_reg < carry_in.old_stamp);

        wr_all  = (carry_in.active && (q.op == OP_SAVE) && !used)
                  || (evict_en && (evict_idx == IW'(IDX)));
        wr_link = wr_all || (carry_in.active && (q.op == OP_SAVE) && match);

        stamp_next = wr_link ? q.now : stamp_reg;

        carry_next.active    = carry_in.active && !stop;
        carry_next.old_stamp = take_old ? stamp_reg : carry_in.old_stamp;
        oidx_next            = take_old ? IW'(IDX) : oidx_in;

        res.found = stop;
        res.hit   = carry_in.active && match;
        res.mac   = (carry_in.active && match && (q.op == OP_LOOKUP)) ? link_reg : '0;
    end

    // a zero stamp marks the entry empty, so only the stamp (and the token) needs reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg <= '0;
            carry_reg <= '0;
        end
        else
        begin
            stamp_reg <= stamp_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oidx_reg <= oidx_next;
        if (wr_all)
        begin
            addr_hi_reg <= q.ip_high;
            addr_lo_reg <= q.ip_low;
        end
        if (wr_link)
        begin
            link_reg <= q.mac;
        end
    end

    assign carry_out = carry_reg;
    assign oidx_out  = oidx_reg;

endmodule
